[hdl/lpr_pkg.sv]
`timescale 1ns / 1ps

package lpr_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef logic [IDX_W-1:0] tbl_idx_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] prefix;
		logic [31:0] mask;
		logic [31:0] next_hop;
		logic [3:0]  port;
	} route_entry_t;

	localparam int ENTRY_W = $bits(route_entry_t);

	// controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic table_wr;
		logic start;
		logic walk;
		logic load_out;
	} lpr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cnt_last;
	} lpr_sts_t;

endpackage

[hdl/lpr_req_if.sv]
`timescale 1ns / 1ps

interface lpr_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [3:0]  entry_index;
	logic        entry_valid;
	logic [31:0] entry_prefix;
	logic [31:0] entry_mask;
	logic [31:0] entry_next_hop;
	logic [3:0]  entry_port;
	logic [31:0] lookup_address;

	modport source (
		output valid, operation, entry_index, entry_valid, entry_prefix, entry_mask,
		output entry_next_hop, entry_port, lookup_address,
		input  ready
	);

	modport sink (
		input  valid, operation, entry_index, entry_valid, entry_prefix, entry_mask,
		input  entry_next_hop, entry_port, lookup_address,
		output ready
	);
endinterface

[hdl/lpr_rsp_if.sv]
`timescale 1ns / 1ps

interface lpr_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [3:0]  match_index;
	logic [31:0] next_hop;
	logic [3:0]  out_port;

	modport source (
		output valid, hit, match_index, next_hop, out_port,
		input  ready
	);

	modport sink (
		input  valid, hit, match_index, next_hop, out_port,
		output ready
	);
endinterface

[hdl/lpr_ram.sv]
`timescale 1ns / 1ps

module lpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/lpr_ctrl.sv]
`timescale 1ns / 1ps

module lpr_ctrl import lpr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_operation,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  lpr_sts_t sts,
	output lpr_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_WALK   = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.clear_wr = (state_q == S_CLEAR);
		cmd.table_wr = accept & (in_operation == OP_WRITE);
		cmd.start    = accept & (in_operation == OP_LOOKUP);
		cmd.walk     = (state_q == S_WALK);
		cmd.load_out = (state_q == S_FINISH) & (~out_valid_q | out_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.cnt_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd.start) state_d = S_WALK;
			end
			S_WALK: begin
				if (sts.cnt_last) state_d = S_DRAIN;
			end
			// last entry's data is compared here
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (cmd.load_out) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/lpr_datapath.sv]
`timescale 1ns / 1ps

module lpr_datapath import lpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  lpr_cmd_t    cmd,
	output lpr_sts_t    sts,
	input  logic [3:0]  entry_index,
	input  logic        entry_valid,
	input  logic [31:0] entry_prefix,
	input  logic [31:0] entry_mask,
	input  logic [31:0] entry_next_hop,
	input  logic [3:0]  entry_port,
	input  logic [31:0] lookup_address,
	output logic        hit,
	output logic [3:0]  match_index,
	output logic [31:0] next_hop,
	output logic [3:0]  out_port
);

	localparam tbl_idx_t LAST_IDX = tbl_idx_t'(TABLE_ENTRIES - 1);

	tbl_idx_t     cnt_q;
	tbl_idx_t     rd_idx_s1;
	logic         rd_vld_s1;
	logic [31:0]  addr_q;

	logic         found_q;
	logic [31:0]  best_mask_q;
	tbl_idx_t     best_idx_q;
	logic [31:0]  best_hop_q;
	logic [3:0]   best_port_q;

	logic         hit_q;
	logic [3:0]   match_index_q;
	logic [31:0]  next_hop_q;
	logic [3:0]   out_port_q;

	logic         wr_in_range;
	logic         ram_we;
	tbl_idx_t     ram_waddr;
	route_entry_t ram_wdata;
	route_entry_t wr_entry;
	logic [ENTRY_W-1:0] ram_rdata;
	route_entry_t rd_entry;
	logic         take;

	assign sts.cnt_last = (cnt_q == LAST_IDX);

	assign wr_in_range = (32'(entry_index) < TABLE_ENTRIES);

	always_comb begin
		wr_entry.valid    = entry_valid;
		wr_entry.prefix   = entry_prefix;
		wr_entry.mask     = entry_mask;
		wr_entry.next_hop = entry_next_hop;
		wr_entry.port     = entry_port;
	end

	// clearing sweep only needs the valid bit low
	assign ram_we    = cmd.clear_wr | (cmd.table_wr & wr_in_range);
	assign ram_waddr = cmd.clear_wr ? cnt_q : tbl_idx_t'(32'(entry_index));
	assign ram_wdata = cmd.clear_wr ? route_entry_t'('0) : wr_entry;

	lpr_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.walk),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	assign rd_entry = route_entry_t'(ram_rdata);

	// ties go to the later slot, hence >=
	assign take = rd_vld_s1 & rd_entry.valid
		& ((addr_q & rd_entry.mask) == rd_entry.prefix)
		& (~found_q | (rd_entry.mask >= best_mask_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.walk;
			if (cmd.start) begin
				cnt_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.walk | cmd.clear_wr) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q <= lookup_address;
		end
		rd_idx_s1 <= cnt_q;
		if (take) begin
			best_mask_q <= rd_entry.mask;
			best_idx_q  <= rd_idx_s1;
			best_hop_q  <= rd_entry.next_hop;
			best_port_q <= rd_entry.port;
		end
		if (cmd.load_out) begin
			hit_q         <= found_q;
			match_index_q <= found_q ? 4'(32'(best_idx_q)) : 4'd0;
			next_hop_q    <= found_q ? best_hop_q : 32'd0;
			out_port_q    <= found_q ? best_port_q : 4'd0;
		end
	end

	assign hit         = hit_q;
	assign match_index = match_index_q;
	assign next_hop    = next_hop_q;
	assign out_port    = out_port_q;

endmodule

[hdl/longest_prefix_route_lookup_top.sv]
`timescale 1ns / 1ps

// IPv4 longest-prefix route table of TABLE_ENTRIES slots held in one RAM. A write word
// (operation 0) stores one slot; a slot index beyond the table is dropped. A lookup
// word (operation 1) walks every slot through the RAM read port, one slot per cycle,
// and keeps the matching valid slot with the largest mask, the higher slot on equal
// masks; it returns one word with hit, slot, next hop and port, all zero on a miss.
// A lookup occupies the block from its accept through the walk, a drain state for the
// last compare and a finish state that loads the output register, and no new word is
// accepted before that load; the finish state waits while an unread result holds the
// register. Writes go at one per cycle while the block is idle. A finished result sits
// in an output register, so the next word is accepted while it waits. After reset a
// clearing pass invalidates every slot, and no word is accepted until it ends.
module longest_prefix_route_lookup_top import lpr_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	lpr_req_if.sink req,
	lpr_rsp_if.source rsp
);

	lpr_cmd_t cmd;
	lpr_sts_t sts;

	lpr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req.valid),
		.in_operation (req.operation),
		.in_ready     (req.ready),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	lpr_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.entry_index    (req.entry_index),
		.entry_valid    (req.entry_valid),
		.entry_prefix   (req.entry_prefix),
		.entry_mask     (req.entry_mask),
		.entry_next_hop (req.entry_next_hop),
		.entry_port     (req.entry_port),
		.lookup_address (req.lookup_address),
		.hit            (rsp.hit),
		.match_index    (rsp.match_index),
		.next_hop       (rsp.next_hop),
		.out_port       (rsp.out_port)
	);

endmodule

[tb/sv/longest_prefix_route_lookup_top_test.sv]
`timescale 1ns / 1ps

module longest_prefix_route_lookup_top_test;
	import lpr_pkg::*;

	localparam int RANDOM_WORDS    = 928;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER  = 40;
	localparam int DRAIN_CYCLES    = 3 * (TABLE_ENTRIES + 3);
	localparam int LIMIT_CYCLES    = 400000;
	localparam int SCRIPT_ROWS     = 22;

	typedef struct packed {
		logic        operation;
		logic [3:0]  entry_index;
		logic        entry_valid;
		logic [31:0] entry_prefix;
		logic [31:0] entry_mask;
		logic [31:0] entry_next_hop;
		logic [3:0]  entry_port;
		logic [31:0] lookup_address;
	} route_word_t;

	typedef struct packed {
		logic        hit;
		logic [3:0]  match_index;
		logic [31:0] next_hop;
		logic [3:0]  out_port;
	} route_answer_t;

	typedef struct {
		route_word_t   word;
		bit            typed;
		route_answer_t answer;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lpr_req_if req_ch ();
	lpr_rsp_if rsp_ch ();

	longest_prefix_route_lookup_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the route table
	logic        tbl_valid    [TABLE_ENTRIES];
	logic [31:0] tbl_prefix   [TABLE_ENTRIES];
	logic [31:0] tbl_mask     [TABLE_ENTRIES];
	logic [31:0] tbl_next_hop [TABLE_ENTRIES];
	logic [3:0]  tbl_port     [TABLE_ENTRIES];

	route_answer_t lookup_answers [$];

	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned writes_sent = 0;
	int unsigned lookups_sent = 0;
	int unsigned answers_seen = 0;
	int unsigned hits_seen = 0;
	int unsigned burst_left = 0;
	bit          held_off = 1'b0;

	// some lookups carry junk entry fields and some writes a junk address, on purpose
	script_row_t script [SCRIPT_ROWS] = '{
		'{'{OP_LOOKUP, 4'hF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF,
			32'h0000_0000}, 1'b1, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_LOOKUP, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0, 4'h0, 32'hFFFF_FFFF},
			1'b1, '{1'b0, 4'd0, 32'h0, 4'd0}},
		// default route in the lowest slot
		'{'{OP_WRITE, 4'h0, 1'b1, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'hF, 32'h1234_5678},
			1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_LOOKUP, 4'h3, 1'b0, 32'h5555_5555, 32'h0, 32'h0, 4'h2, 32'hFFFF_FFFF},
			1'b1, '{1'b1, 4'd0, 32'hFFFF_FFFF, 4'hF}},
		// host route in the highest slot
		'{'{OP_WRITE, 4'hF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 4'h0, 32'hAAAA_AAAA},
			1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_LOOKUP, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0, 4'h0, 32'hFFFF_FFFF},
			1'b1, '{1'b1, 4'hF, 32'h0, 4'h0}},
		'{'{OP_LOOKUP, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0, 4'h0, 32'hFFFF_FFFE},
			1'b1, '{1'b1, 4'd0, 32'hFFFF_FFFF, 4'hF}},
		'{'{OP_WRITE, 4'h5, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 4'h3,
			32'h0}, 1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_WRITE, 4'h6, 1'b1, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 4'h4,
			32'h0}, 1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_LOOKUP, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0A01_0203},
			1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_LOOKUP, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0A02_0304},
			1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		// same mask as slot 5, higher slot must win
		'{'{OP_WRITE, 4'h9, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FD, 4'h9,
			32'h0}, 1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_LOOKUP, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0A7F_0000},
			1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		// prefix bit outside its mask, never matches
		'{'{OP_WRITE, 4'h7, 1'b1, 32'h0000_0001, 32'hFF00_0000, 32'h0707_0707, 4'h7,
			32'h0}, 1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_LOOKUP, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0000_0001},
			1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		// non-contiguous mask, ranked as a plain number
		'{'{OP_WRITE, 4'h8, 1'b1, 32'h1010_1010, 32'hF0F0_F0F0, 32'h0808_0808, 4'h8,
			32'h0}, 1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_LOOKUP, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h1F1F_1F1F},
			1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		// remove slot 6 but keep its fields
		'{'{OP_WRITE, 4'h6, 1'b0, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_00FE, 4'h4,
			32'h0}, 1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_LOOKUP, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0A01_0203},
			1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_WRITE, 4'h0, 1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'hF, 32'h0},
			1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_LOOKUP, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0102_0304},
			1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}},
		'{'{OP_LOOKUP, 4'h0, 1'b0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0A00_00FF},
			1'b0, '{1'b0, 4'd0, 32'h0, 4'd0}}
	};

	function automatic void store_route(input route_word_t w);
		if (w.entry_index < TABLE_ENTRIES) begin
			tbl_valid[w.entry_index]    = w.entry_valid;
			tbl_prefix[w.entry_index]   = w.entry_prefix;
			tbl_mask[w.entry_index]     = w.entry_mask;
			tbl_next_hop[w.entry_index] = w.entry_next_hop;
			tbl_port[w.entry_index]     = w.entry_port;
		end
	endfunction

	function automatic route_answer_t route_lookup(input logic [31:0] addr);
		route_answer_t a;
		bit            found;
		int            best;
		a = '0;
		found = 1'b0;
		best = 0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (tbl_valid[i] && ((addr & tbl_mask[i]) == tbl_prefix[i])
					&& (!found || tbl_mask[i] >= tbl_mask[best])) begin
				found = 1'b1;
				best = i;
			end
		end
		if (found) begin
			a.hit = 1'b1;
			a.match_index = 4'(best);
			a.next_hop = tbl_next_hop[best];
			a.out_port = tbl_port[best];
		end
		return a;
	endfunction

	// mostly well-formed routes from a small prefix pool so that overlaps and ties happen
	function automatic route_word_t make_random_word();
		route_word_t w;
		int unsigned pick;
		int unsigned len;
		int unsigned slot;
		logic [31:0] base;
		w.operation = OP_LOOKUP;
		w.entry_index = 4'($urandom);
		w.entry_valid = 1'($urandom);
		w.entry_prefix = $urandom;
		w.entry_mask = $urandom;
		w.entry_next_hop = $urandom;
		w.entry_port = 4'($urandom);
		w.lookup_address = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			w.operation = OP_WRITE;
			w.entry_valid = ($urandom_range(0, 9) != 0);
			len = ($urandom_range(0, 1) == 1) ? 8 * $urandom_range(1, 3) : $urandom_range(0, 32);
			w.entry_mask = 32'hFFFF_FFFF << (32 - len);
			if ($urandom_range(0, 19) == 0)
				w.entry_mask = $urandom;
			base = {8'($urandom_range(10, 12)), 8'($urandom_range(0, 3)),
				8'($urandom_range(0, 3)), 8'($urandom)};
			if ($urandom_range(0, 4) == 0)
				base = $urandom;
			w.entry_prefix = base & w.entry_mask;
			if ($urandom_range(0, 19) == 0)
				w.entry_prefix = $urandom;
		end else if (pick < 90) begin
			slot = $urandom_range(0, TABLE_ENTRIES - 1);
			w.lookup_address = (tbl_prefix[slot] & tbl_mask[slot]) | ($urandom & ~tbl_mask[slot]);
		end
		return w;
	endfunction

	task automatic pace_sender();
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
	endtask

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_word(input route_word_t w, input bit typed, input route_answer_t answer);
		route_answer_t predicted;
		req_ch.valid          <= 1'b1;
		req_ch.operation      <= w.operation;
		req_ch.entry_index    <= w.entry_index;
		req_ch.entry_valid    <= w.entry_valid;
		req_ch.entry_prefix   <= w.entry_prefix;
		req_ch.entry_mask     <= w.entry_mask;
		req_ch.entry_next_hop <= w.entry_next_hop;
		req_ch.entry_port     <= w.entry_port;
		req_ch.lookup_address <= w.lookup_address;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (w.operation == OP_LOOKUP) begin
			predicted = route_lookup(w.lookup_address);
			lookup_answers.push_back(typed ? answer : predicted);
			lookups_sent++;
		end else begin
			store_route(w);
			writes_sent++;
		end
		@(negedge clk);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_answer(input route_answer_t got);
		route_answer_t want;
		if (lookup_answers.size() == 0) begin
			$display("%0t: unexpected result word, expected none, actual hit %0b slot %0d hop %h port %0d",
				$time, got.hit, got.match_index, got.next_hop, got.out_port);
			errors++;
		end else begin
			want = lookup_answers.pop_front();
			compare_field("hit", 32'(want.hit), 32'(got.hit));
			compare_field("match_index", 32'(want.match_index), 32'(got.match_index));
			compare_field("next_hop", want.next_hop, got.next_hop);
			compare_field("out_port", 32'(want.out_port), 32'(got.out_port));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			check_answer('{rsp_ch.hit, rsp_ch.match_index, rsp_ch.next_hop, rsp_ch.out_port});
			answers_seen++;
			if (rsp_ch.hit)
				hits_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, lookup_answers.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random stall modes plus one long hold-off so the block backs up
	initial begin : receiver
		int unsigned mode;
		int unsigned phase_left;
		mode = 0;
		phase_left = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && answers_seen >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				if (phase_left == 0) begin
					mode = $urandom_range(0, 3);
					phase_left = $urandom_range(20, 80);
				end
				phase_left--;
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= ((phase_left % 6) < 2);
					default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	initial begin : sender
		route_word_t w;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_WRITE;
		req_ch.entry_index = '0;
		req_ch.entry_valid = 1'b0;
		req_ch.entry_prefix = '0;
		req_ch.entry_mask = '0;
		req_ch.entry_next_hop = '0;
		req_ch.entry_port = '0;
		req_ch.lookup_address = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_prefix[i] = '0;
			tbl_mask[i] = '0;
			tbl_next_hop[i] = '0;
			tbl_port[i] = '0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			pace_sender();
			send_word(script[i].word, script[i].typed, script[i].answer);
		end
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pace_sender();
			w = make_random_word();
			send_word(w, 1'b0, '0);
		end
		req_ch.valid <= 1'b0;

		wait (lookup_answers.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (lookup_answers.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, lookup_answers.size());
			errors += lookup_answers.size();
		end

		$display("sent %0d table writes and %0d lookups; %0d results came back, %0d of them hits",
			writes_sent, lookups_sent, answers_seen, hits_seen);
		$display("output held off for %0d cycles once, with %0d mismatches", HOLD_OFF_CYCLES, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
hdl/lpr_pkg.sv
hdl/lpr_req_if.sv
hdl/lpr_rsp_if.sv
hdl/lpr_ram.sv
hdl/lpr_ctrl.sv
hdl/lpr_datapath.sv
hdl/longest_prefix_route_lookup_top.sv
tb/sv/longest_prefix_route_lookup_top_test.sv
